[design/obook_pkg.sv]
`default_nettype none

package obook_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int POS_W   = 7;
  localparam int IN_W    = 32;
  localparam int VAL_W   = 31;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_BADPOS = 3'd1,
    ST_NEG    = 3'd2,
    ST_FULL   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

endpackage

`default_nettype wire

[design/obook_if.sv]
`default_nettype none

interface obook_in_if import obook_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [POS_W-1:0]        position;
  logic signed [IN_W-1:0]  price;
  logic signed [IN_W-1:0]  quantity;

  modport source (output valid, cmd, position, price, quantity, input ready);
  modport sink (input valid, cmd, position, price, quantity, output ready);
endinterface

interface obook_out_if import obook_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [POS_W-1:0]     entry_position;
  logic [VAL_W-1:0]     entry_price;
  logic [VAL_W-1:0]     entry_quantity;
  logic [COUNT_W-1:0]   entry_count;
  logic                 last;

  modport source (output valid, status, entry_position, entry_price, entry_quantity,
                  entry_count, last, input ready);
  modport sink (input valid, status, entry_position, entry_price, entry_quantity,
                entry_count, last, output ready);
endinterface

`default_nettype wire

[design/obook_check.sv]
`default_nettype none

module obook_check import obook_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  cmd_t             cmd,
  input  logic [POS_W-1:0] position,
  input  logic             neg,
  input  logic [CW-1:0]    count,
  output status_t          status
);

  logic [POS_W:0] pos_x;
  logic [POS_W:0] cnt_x;
  logic           bad;
  logic           full;

  always_comb begin
    pos_x = {1'b0, position};
    cnt_x = (POS_W + 1)'(count);
    full  = (cnt_x == (POS_W + 1)'(DEPTH));
    if (cmd == CMD_INSERT) begin
      bad = (position == '0) || (pos_x > cnt_x + 1'b1);
    end else begin
      bad = (position == '0) || (pos_x > cnt_x);
    end
    if (bad) begin
      status = ST_BADPOS;
    end else if (neg) begin
      status = ST_NEG;
    end else if (cmd == CMD_INSERT && full) begin
      status = ST_FULL;
    end else begin
      status = ST_OK;
    end
  end

endmodule

`default_nettype wire

[design/positional_order_book.sv]
// channel  dir  words                                   handshake
// req      in   cmd, position, price, quantity         valid / ready
// rsp      out  status, entry_position, entry_price,   valid / ready
//               entry_quantity, entry_count, last
//
// one word at a time; ready is high only while the sequencer is idle
// update, or any rejected word: the sequencer goes straight from idle to the result word
// insert at p: moves count - p + 1 levels (each read, then written), then puts the new level
// delete at p: moves count - p levels (each read, then written), then answers
// dump: each level is read from the level store, then handed out once the output is free
// synchronous reset empties the book at once; a stalled rsp holds the sequencer
`default_nettype none

module positional_order_book import obook_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic          clk,
  input logic          rst,
  obook_in_if.sink     req,
  obook_out_if.source  rsp
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = 2 * VAL_W;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_RD       = 6'b000010,
    S_WR       = 6'b000100,
    S_PUT      = 6'b001000,
    S_RESP     = 6'b010000,
    S_DUMP_RD  = 6'b100000
  } state_t;

  // dump output step uses its own read state, S_DUMP_RD, below
  state_t            state;
  logic              dump_out;
  cmd_t              op;
  logic [CW-1:0]     count;
  logic [CW-1:0]     ptr;
  logic [IW-1:0]     lo;
  logic [VAL_W-1:0]  new_price;
  logic [VAL_W-1:0]  new_qty;
  status_t           st;

  logic [MW-1:0]     mem [DEPTH];
  logic [MW-1:0]     rdata;
  logic              we;
  logic [IW-1:0]     waddr;
  logic [IW-1:0]     raddr;
  logic [MW-1:0]     wdata;

  logic              out_valid;
  status_t           out_status;
  logic [POS_W-1:0]  out_pos;
  logic [VAL_W-1:0]  out_price;
  logic [VAL_W-1:0]  out_qty;
  logic [COUNT_W-1:0] out_count;
  logic              out_last;
  logic              out_free;
  logic              out_load;

  cmd_t              in_cmd;
  status_t           chk;
  logic [POS_W-1:0]  pm1;
  logic [IW-1:0]     pidx;
  logic [CW-1:0]     ptr_up;
  logic [CW-1:0]     ptr_dn;
  logic              accept;

  assign in_cmd   = cmd_t'(req.cmd);
  assign pm1      = req.position - 1'b1;
  assign pidx     = pm1[IW-1:0];
  assign ptr_up   = ptr + 1'b1;
  assign ptr_dn   = ptr - 1'b1;
  assign req.ready = (state == S_IDLE);
  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign out_load = out_free && ((state == S_RESP) || (state == S_DUMP_RD && dump_out));

  obook_check #(.DEPTH(DEPTH)) u_check (
    .cmd      (in_cmd),
    .position (req.position),
    .neg      (req.price[IN_W-1] | req.quantity[IN_W-1]),
    .count    (count),
    .status   (chk)
  );

  always_comb begin
    we    = 1'b0;
    waddr = ptr[IW-1:0];
    wdata = rdata;
    raddr = ptr[IW-1:0];
    unique case (state)
      S_IDLE: begin
        waddr = pidx;
        wdata = {req.price[VAL_W-1:0], req.quantity[VAL_W-1:0]};
        we    = accept && (in_cmd == CMD_UPDATE) && (chk == ST_OK);
      end
      S_RD: begin
        raddr = (op == CMD_INSERT) ? ptr_dn[IW-1:0] : ptr_up[IW-1:0];
      end
      S_WR: begin
        we = 1'b1;
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = lo;
        wdata = {new_price, new_qty};
      end
      S_RESP, S_DUMP_RD: begin
        raddr = ptr[IW-1:0];
      end
      default: begin
        raddr = ptr[IW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dump_out  <= 1'b0;
      count     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= in_cmd;
            if (in_cmd == CMD_DUMP) begin
              ptr <= '0;
              if (count == '0) begin
                st    <= ST_EMPTY;
                state <= S_RESP;
              end else begin
                dump_out <= 1'b0;
                state    <= S_DUMP_RD;
              end
            end else begin
              st <= chk;
              if (chk != ST_OK) begin
                state <= S_RESP;
              end else begin
                unique case (in_cmd)
                  CMD_INSERT: begin
                    new_price <= req.price[VAL_W-1:0];
                    new_qty   <= req.quantity[VAL_W-1:0];
                    lo        <= pidx;
                    ptr       <= count;
                    state     <= (count == CW'(pidx)) ? S_PUT : S_RD;
                  end
                  CMD_DELETE: begin
                    ptr <= CW'(pidx);
                    if (CW'(pidx) + 1'b1 == count) begin
                      count <= count - 1'b1;
                      state <= S_RESP;
                    end else begin
                      state <= S_RD;
                    end
                  end
                  default: begin
                    state <= S_RESP;
                  end
                endcase
              end
            end
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (op == CMD_INSERT) begin
            ptr   <= ptr_dn;
            state <= (ptr_dn == CW'(lo)) ? S_PUT : S_RD;
          end else begin
            ptr <= ptr_up;
            if (ptr_up + 1'b1 == count) begin
              count <= count - 1'b1;
              state <= S_RESP;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_PUT: begin
          count <= count + 1'b1;
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_status <= st;
            out_pos    <= '0;
            out_price  <= '0;
            out_qty    <= '0;
            out_count  <= COUNT_W'(count);
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_DUMP_RD: begin
          // with dump_out low the read is issued; with it high the level is handed out once the output is free
          if (!dump_out) begin
            dump_out <= 1'b1;
          end else if (out_free) begin
            out_status <= ST_OK;
            out_pos    <= POS_W'(ptr_up);
            out_price  <= rdata[MW-1:VAL_W];
            out_qty    <= rdata[VAL_W-1:0];
            out_count  <= COUNT_W'(count);
            out_last   <= (ptr_up == count);
            dump_out   <= 1'b0;
            if (ptr_up == count) begin
              state <= S_IDLE;
            end else begin
              ptr <= ptr_up;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.entry_position = out_pos;
  assign rsp.entry_price    = out_price;
  assign rsp.entry_quantity = out_qty;
  assign rsp.entry_count    = out_count;
  assign rsp.last           = out_last;

endmodule

`default_nettype wire

[design/obook_sva.sv]
`default_nettype none

module obook_sva import obook_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [STAT_W-1:0]  rsp_status,
  input logic [POS_W-1:0]   rsp_position,
  input logic [COUNT_W-1:0] rsp_count,
  input logic               rsp_last
);

  // a stalled word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_position) && $stable(rsp_count) && $stable(rsp_last))
    else $error("rsp word changed under stall");

  // busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready right after accept");

  // idle with a pending word means the item is finished
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    req_ready && rsp_valid |-> rsp_last)
    else $error("idle while item still has words");

  // only dumped levels come before the last word of an item
  a_mid_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> rsp_status == ST_OK && rsp_position != '0)
    else $error("non-last word is not a dumped level");

  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_count <= COUNT_W'(DEPTH))
    else $error("count beyond depth");

endmodule

bind positional_order_book obook_sva #(.DEPTH(DEPTH)) u_obook_sva (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_position (rsp.entry_position),
  .rsp_count    (rsp.entry_count),
  .rsp_last     (rsp.last)
);

`default_nettype wire
